// ===== rtl/core/tpre_pkg.sv =====
// Shared types, widths and helpers for the two-plate radius estimator.
`timescale 1ns / 1ps
package tpre_pkg;

	// Averaging window and sample counter
	localparam int WINDOW_SIZE = 1024;
	localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
	localparam int COUNT_OUT_W = 11;

	// Field and datapath widths
	localparam int FRAC    = 14;
	localparam int DIR_W   = 16;
	localparam int POS_W   = 32;
	localparam int DIFF_W  = 33;
	localparam int VEC_W   = 32;
	localparam int UNIT_W  = 16;
	localparam int AXZ_W   = 15;
	localparam int BS_W    = 35;
	localparam int K_W     = 17;
	localparam int DEN_W   = 33;
	localparam int NUM_W   = 53;
	localparam int RAD_W   = 32;
	localparam int SUM_W   = 48;

	// Shared multiplier
	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 33;
	localparam int MUL_W   = MUL_A_W + MUL_B_W;

	// Shared divider and square root
	localparam int DIV_W     = 68;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int UNIT_BITS = 47;
	localparam int AVG_BITS  = 49;
	localparam int RAD_BITS  = DIV_W;
	localparam int SQ_W      = 64;
	localparam int ROOT_W    = SQ_W / 2;

	localparam logic [MUL_W-1:0] HALF_LSB = MUL_W'(1) << (FRAC - 1);
	localparam logic signed [MUL_W-1:0] ONE_Q28 = MUL_W'(1) << (2 * FRAC);

	typedef enum logic [4:0] {
		S_IDLE, S_CR_M1, S_CR_M2, S_CR_W, S_SQ_M, S_SQ_A, S_SQRT, S_SQRT_W,
		S_UN_DIV, S_UN_W, S_DOT_M, S_DOT_A, S_DOT_R, S_DEN_M, S_DEN_W,
		S_NUM_M1, S_NUM_M2, S_NUM_W, S_RAD_DIV, S_RAD_W, S_ACC,
		S_AVG_DIV, S_AVG_W, S_DONE
	} state_t;

	typedef enum logic [1:0] {PASS_AXIS, PASS_N1, PASS_N2} pass_t;
	typedef enum logic [1:0] {DOT_B1, DOT_B2, DOT_K} dot_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     num;
		logic [DEN_W-1:0]     den;
		logic [DIV_CNT_W-1:0] bits;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic            start;
		logic [SQ_W-1:0] rad;
	} sqrt_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

	// Cyclic successors of a vector index
	function automatic logic [1:0] idx_next1(input logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : i + 2'd1;
	endfunction

	function automatic logic [1:0] idx_next2(input logic [1:0] i);
		return (i == 2'd0) ? 2'd2 : i - 2'd1;
	endfunction

	// Drop FRAC fraction bits, round to nearest, ties away from zero
	function automatic logic signed [MUL_W-1:0] round_frac(input logic signed [MUL_W-1:0] v);
		logic [MUL_W-1:0] m;
		logic [MUL_W-1:0] q;
		m = v[MUL_W-1] ? MUL_W'(-v) : MUL_W'(v);
		q = (m + HALF_LSB) >> FRAC;
		return v[MUL_W-1] ? -$signed(q) : $signed(q);
	endfunction

endpackage

// ===== rtl/core/tpre_if.sv =====
// Valid/ready channel interfaces for plate pairs and estimator results.
`timescale 1ns / 1ps
interface tpre_in_if import tpre_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [DIR_W-1:0] dir_a_x;
	logic signed [DIR_W-1:0] dir_a_y;
	logic signed [DIR_W-1:0] dir_a_z;
	logic signed [POS_W-1:0] pos_a_x;
	logic signed [POS_W-1:0] pos_a_y;
	logic signed [POS_W-1:0] pos_a_z;
	logic signed [DIR_W-1:0] dir_b_x;
	logic signed [DIR_W-1:0] dir_b_y;
	logic signed [DIR_W-1:0] dir_b_z;
	logic signed [POS_W-1:0] pos_b_x;
	logic signed [POS_W-1:0] pos_b_y;
	logic signed [POS_W-1:0] pos_b_z;

	modport source (output valid, dir_a_x, dir_a_y, dir_a_z, pos_a_x, pos_a_y, pos_a_z,
		dir_b_x, dir_b_y, dir_b_z, pos_b_x, pos_b_y, pos_b_z, input ready);
	modport sink (input valid, dir_a_x, dir_a_y, dir_a_z, pos_a_x, pos_a_y, pos_a_z,
		dir_b_x, dir_b_y, dir_b_z, pos_b_x, pos_b_y, pos_b_z, output ready);
endinterface

interface tpre_out_if import tpre_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [UNIT_W-1:0] axis_x;
	logic signed [UNIT_W-1:0] axis_y;
	logic [AXZ_W-1:0]         axis_z;
	logic signed [RAD_W-1:0]  radius_one_avg;
	logic signed [RAD_W-1:0]  radius_two_avg;
	logic                     degenerate;
	logic                     window_cleared;
	logic [COUNT_OUT_W-1:0]   sample_count;

	modport source (output valid, axis_x, axis_y, axis_z, radius_one_avg, radius_two_avg,
		degenerate, window_cleared, sample_count, input ready);
	modport sink (input valid, axis_x, axis_y, axis_z, radius_one_avg, radius_two_avg,
		degenerate, window_cleared, sample_count, output ready);
endinterface

// ===== rtl/core/tpre_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tpre_div import tpre_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_W-1:0]     num_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DEN_W:0]       rem_sh;
	logic                 ge;

	// Bring down the next numerator bit and trial-subtract
	assign rem_sh = {rem_q, num_q[DIV_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.bits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift numerator out, quotient in
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ===== rtl/core/tpre_sqrt.sv =====
// Shared digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module tpre_sqrt import tpre_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sqrt_req_t req,
	output sqrt_rsp_t rsp
);

	localparam int SQ_CNT_W = $clog2(ROOT_W + 1);

	logic [SQ_W-1:0]     rad_q;
	logic [ROOT_W+1:0]   rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [SQ_CNT_W-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [ROOT_W+3:0]   rem_sh;
	logic [ROOT_W+3:0]   trial;
	logic                ge;

	// Bring down two radicand bits and test the next root bit
	assign rem_sh = {rem_q, rad_q[SQ_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQ_CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SQ_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? (ROOT_W+2)'(rem_sh - trial) : (ROOT_W+2)'(rem_sh);
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

// ===== rtl/core/two_plate_radius_estimator_unit.sv =====
// Top level of the two-plate radius estimator: sequencer, shared multiplier and datapath.
`timescale 1ns / 1ps
// Takes one plate pair at a time and returns one result transaction per pair. A pair
// with good geometry spends most of its time in the shared one-bit-per-cycle divider
// (nine unit-vector divisions of 47 quotient bits, two radius divisions of 68 bits, two
// average divisions of 49 bits), plus three 32-bit square roots and a shared registered
// multiplier that forms every product one per cycle. Degenerate pairs and pairs that
// arrive on a full window finish early. The block is ready again once the previous result
// sits in the output register. Averages are over up to WINDOW_SIZE samples; the pair that
// finds the window full clears the sums and count and is not itself counted.
module two_plate_radius_estimator_unit import tpre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tpre_in_if.sink    plates,
	tpre_out_if.source result
);

	state_t state_q, state_d;
	pass_t  pass_q;
	dot_t   dot_q;
	logic [1:0] idx_q;
	logic [1:0] j_idx, k_idx;

	// Item operands and intermediate vectors
	logic signed [DIR_W-1:0]  da_q [3];
	logic signed [DIR_W-1:0]  db_q [3];
	logic signed [DIFF_W-1:0] dp_q [3];
	logic signed [VEC_W-1:0]  vec_q [3];
	logic signed [UNIT_W-1:0] ax_q [3];
	logic signed [UNIT_W-1:0] n1_q [3];
	logic signed [UNIT_W-1:0] n2_q [3];
	logic signed [MUL_W-1:0]  acc_q;
	logic signed [MUL_W-1:0]  mp_q;
	logic [ROOT_W-1:0]        norm_q;
	logic signed [BS_W-1:0]   b1s_q, b2s_q;
	logic signed [K_W-1:0]    k14_q;
	logic signed [DEN_W-1:0]  den_q;
	logic signed [NUM_W-1:0]  num_q [2];
	logic signed [RAD_W-1:0]  rad_q [2];
	logic                     cleared_q, degen_q;

	// Running state
	logic [CNT_W-1:0]         total_q;
	logic signed [SUM_W-1:0]  sum_q [2];
	logic signed [RAD_W-1:0]  held_q [2];

	// Output register
	logic                     out_valid_q;
	logic signed [UNIT_W-1:0] o_ax_q, o_ay_q;
	logic [AXZ_W-1:0]         o_az_q;
	logic signed [RAD_W-1:0]  o_r1_q, o_r2_q;
	logic                     o_degen_q, o_clr_q;
	logic [COUNT_OUT_W-1:0]   o_cnt_q;

	// Shared units
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	div_req_t  div_req;
	div_rsp_t  div_rsp;
	sqrt_req_t sqrt_req;
	sqrt_rsp_t sqrt_rsp;

	// Combinational helpers
	logic                     accept, out_free, window_full;
	logic signed [DIR_W-1:0]  u_j, u_k, w_j, w_k;
	logic signed [VEC_W-1:0]  vsel;
	logic [VEC_W-1:0]         vmag;
	logic [UNIT_BITS-1:0]     un_num;
	logic [NUM_W-1:0]         nmag;
	logic [DEN_W-1:0]         dmag;
	logic [SUM_W-1:0]         smag;
	logic [AVG_BITS-1:0]      avg_num;
	logic signed [DEN_W-1:0]  den_c;
	logic [UNIT_W-1:0]        uq;
	logic                     uneg;
	logic signed [UNIT_W-1:0] uval;
	logic                     rneg;
	logic signed [RAD_W-1:0]  rad_sat;
	logic signed [RAD_W-1:0]  avg_val;

	tpre_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	tpre_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sqrt_req), .rsp(sqrt_rsp));

	assign accept      = plates.valid && plates.ready;
	assign out_free    = !out_valid_q || result.ready;
	assign window_full = total_q >= CNT_W'(WINDOW_SIZE);
	assign j_idx       = idx_next1(idx_q);
	assign k_idx       = idx_next2(idx_q);

	// Cross-product operands for the current pass
	assign u_j = (pass_q == PASS_AXIS) ? da_q[j_idx] : ax_q[j_idx];
	assign u_k = (pass_q == PASS_AXIS) ? da_q[k_idx] : ax_q[k_idx];
	assign w_j = (pass_q == PASS_N1) ? da_q[j_idx] : db_q[j_idx];
	assign w_k = (pass_q == PASS_N1) ? da_q[k_idx] : db_q[k_idx];

	// Magnitudes and rounded numerators for the divider
	assign vsel    = vec_q[idx_q];
	assign vmag    = vsel[VEC_W-1] ? VEC_W'(-vsel) : VEC_W'(vsel);
	assign un_num  = UNIT_BITS'({vmag, {FRAC{1'b0}}}) + UNIT_BITS'(norm_q[ROOT_W-1:1]);
	assign nmag    = num_q[idx_q[0]][NUM_W-1] ? NUM_W'(-num_q[idx_q[0]])
		: NUM_W'(num_q[idx_q[0]]);
	assign dmag    = den_q[DEN_W-1] ? DEN_W'(-den_q) : DEN_W'(den_q);
	assign smag    = sum_q[idx_q[0]][SUM_W-1] ? SUM_W'(-sum_q[idx_q[0]])
		: SUM_W'(sum_q[idx_q[0]]);
	assign avg_num = AVG_BITS'(smag) + AVG_BITS'(total_q[CNT_W-1:1]);
	assign den_c   = DEN_W'(ONE_Q28 - mp_q);

	// Signed unit component; flip the axis when its z part is negative
	assign uq   = div_rsp.quo[UNIT_W-1:0];
	assign uneg = vsel[VEC_W-1] ^ ((pass_q == PASS_AXIS) && vec_q[2][VEC_W-1]);
	assign uval = uneg ? -$signed(uq) : $signed(uq);

	// Saturate a radius quotient to the signed 32-bit range
	assign rneg = num_q[idx_q[0]][NUM_W-1] ^ den_q[DEN_W-1];
	always_comb begin
		if (rneg) begin
			rad_sat = (div_rsp.quo >= (DIV_W'(1) << (RAD_W - 1))) ? {1'b1, {(RAD_W-1){1'b0}}}
				: -$signed(div_rsp.quo[RAD_W-1:0]);
		end else begin
			rad_sat = (div_rsp.quo >= ((DIV_W'(1) << (RAD_W - 1)) - DIV_W'(1)))
				? {1'b0, {(RAD_W-1){1'b1}}} : $signed(div_rsp.quo[RAD_W-1:0]);
		end
	end

	assign avg_val = sum_q[idx_q[0]][SUM_W-1] ? -$signed(div_rsp.quo[RAD_W-1:0])
		: $signed(div_rsp.quo[RAD_W-1:0]);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (plates.valid) state_d = S_CR_M1;
			S_CR_M1:   state_d = S_CR_M2;
			S_CR_M2:   state_d = S_CR_W;
			S_CR_W:    state_d = (idx_q == 2'd2) ? S_SQ_M : S_CR_M1;
			S_SQ_M:    state_d = S_SQ_A;
			S_SQ_A:    state_d = (idx_q == 2'd2) ? S_SQRT : S_SQ_M;
			S_SQRT:    state_d = S_SQRT_W;
			S_SQRT_W: begin
				if (sqrt_rsp.done) state_d = (sqrt_rsp.root == '0) ? S_DONE : S_UN_DIV;
			end
			S_UN_DIV:  state_d = S_UN_W;
			S_UN_W: begin
				if (div_rsp.done) begin
					if (idx_q != 2'd2) state_d = S_UN_DIV;
					else state_d = (pass_q == PASS_N2) ? S_DOT_M : S_CR_M1;
				end
			end
			S_DOT_M:   state_d = S_DOT_A;
			S_DOT_A:   state_d = (idx_q == 2'd2) ? S_DOT_R : S_DOT_M;
			S_DOT_R:   state_d = (dot_q == DOT_K) ? S_DEN_M : S_DOT_M;
			S_DEN_M:   state_d = S_DEN_W;
			S_DEN_W:   state_d = (den_c == '0 || cleared_q) ? S_DONE : S_NUM_M1;
			S_NUM_M1:  state_d = S_NUM_M2;
			S_NUM_M2:  state_d = S_NUM_W;
			S_NUM_W:   state_d = S_RAD_DIV;
			S_RAD_DIV: state_d = S_RAD_W;
			S_RAD_W: begin
				if (div_rsp.done) state_d = idx_q[0] ? S_ACC : S_RAD_DIV;
			end
			S_ACC:     state_d = S_AVG_DIV;
			S_AVG_DIV: state_d = S_AVG_W;
			S_AVG_W: begin
				if (div_rsp.done) state_d = idx_q[0] ? S_DONE : S_AVG_DIV;
			end
			S_DONE:    if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Unit operands and handshake outputs
	always_comb begin
		plates.ready = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		div_req      = '0;
		sqrt_req     = '0;
		case (state_q)
			S_IDLE: plates.ready = 1'b1;
			S_CR_M1: begin
				mul_a = MUL_A_W'(u_j);
				mul_b = MUL_B_W'(w_k);
			end
			S_CR_M2: begin
				mul_a = MUL_A_W'(u_k);
				mul_b = MUL_B_W'(w_j);
			end
			S_SQ_M: begin
				mul_a = MUL_A_W'(vsel);
				mul_b = MUL_B_W'(vsel);
			end
			S_SQRT: begin
				sqrt_req.start = 1'b1;
				sqrt_req.rad   = acc_q[SQ_W-1:0];
			end
			S_UN_DIV: begin
				div_req.start = 1'b1;
				div_req.num   = {un_num, {(DIV_W-UNIT_BITS){1'b0}}};
				div_req.den   = DEN_W'(norm_q);
				div_req.bits  = DIV_CNT_W'(UNIT_BITS);
			end
			S_DOT_M: begin
				case (dot_q)
					DOT_B1: begin
						mul_a = MUL_A_W'(dp_q[idx_q]);
						mul_b = MUL_B_W'(n1_q[idx_q]);
					end
					DOT_B2: begin
						mul_a = MUL_A_W'(dp_q[idx_q]);
						mul_b = MUL_B_W'(n2_q[idx_q]);
					end
					default: begin
						mul_a = MUL_A_W'(n1_q[idx_q]);
						mul_b = MUL_B_W'(n2_q[idx_q]);
					end
				endcase
			end
			S_DEN_M: begin
				mul_a = MUL_A_W'(k14_q);
				mul_b = MUL_B_W'(k14_q);
			end
			S_NUM_M1: begin
				mul_a = MUL_A_W'(b2s_q);
				mul_b = MUL_B_W'(k14_q);
			end
			S_NUM_M2: begin
				mul_a = MUL_A_W'(b1s_q);
				mul_b = MUL_B_W'(k14_q);
			end
			S_RAD_DIV: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_W'({nmag, {FRAC{1'b0}}}) + DIV_W'(dmag[DEN_W-1:1]);
				div_req.den   = dmag;
				div_req.bits  = DIV_CNT_W'(RAD_BITS);
			end
			S_AVG_DIV: begin
				div_req.start = 1'b1;
				div_req.num   = {avg_num, {(DIV_W-AVG_BITS){1'b0}}};
				div_req.den   = DEN_W'(total_q);
				div_req.bits  = DIV_CNT_W'(AVG_BITS);
			end
			default: ;
		endcase
	end

	// Control, counters and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= PASS_AXIS;
			dot_q       <= DOT_B1;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			total_q     <= '0;
			sum_q[0]    <= '0;
			sum_q[1]    <= '0;
			held_q[0]   <= '0;
			held_q[1]   <= '0;
		end else begin
			state_q <= state_d;
			// Load a new result or drop the one just taken
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (result.valid && result.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q  <= '0;
						pass_q <= PASS_AXIS;
						dot_q  <= DOT_B1;
						if (window_full) begin
							total_q  <= '0;
							sum_q[0] <= '0;
							sum_q[1] <= '0;
						end
					end
				end
				S_CR_W, S_SQ_A, S_DOT_A: idx_q <= idx_next1(idx_q);
				S_SQRT_W: if (sqrt_rsp.done) idx_q <= '0;
				S_UN_W: begin
					if (div_rsp.done) begin
						idx_q <= idx_next1(idx_q);
						if (idx_q == 2'd2 && pass_q == PASS_AXIS) pass_q <= PASS_N1;
						if (idx_q == 2'd2 && pass_q == PASS_N1) pass_q <= PASS_N2;
					end
				end
				S_DOT_R: dot_q <= (dot_q == DOT_B1) ? DOT_B2 : DOT_K;
				S_NUM_W: idx_q <= '0;
				S_RAD_W: if (div_rsp.done) idx_q <= {1'b0, ~idx_q[0]};
				S_ACC: begin
					sum_q[0] <= sum_q[0] + SUM_W'(rad_q[0]);
					sum_q[1] <= sum_q[1] + SUM_W'(rad_q[1]);
					total_q  <= total_q + 1'b1;
				end
				S_AVG_W: begin
					if (div_rsp.done) begin
						held_q[idx_q[0]] <= avg_val;
						idx_q <= {1'b0, ~idx_q[0]};
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		mp_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					da_q[0]   <= plates.dir_a_x;
					da_q[1]   <= plates.dir_a_y;
					da_q[2]   <= plates.dir_a_z;
					db_q[0]   <= plates.dir_b_x;
					db_q[1]   <= plates.dir_b_y;
					db_q[2]   <= plates.dir_b_z;
					dp_q[0]   <= DIFF_W'(plates.pos_b_x) - DIFF_W'(plates.pos_a_x);
					dp_q[1]   <= DIFF_W'(plates.pos_b_y) - DIFF_W'(plates.pos_a_y);
					dp_q[2]   <= DIFF_W'(plates.pos_b_z) - DIFF_W'(plates.pos_a_z);
					ax_q[0]   <= '0;
					ax_q[1]   <= '0;
					ax_q[2]   <= '0;
					cleared_q <= window_full;
					degen_q   <= 1'b0;
				end
			end
			S_CR_M2: acc_q <= mp_q;
			S_CR_W: begin
				vec_q[idx_q] <= VEC_W'(acc_q - mp_q);
				if (idx_q == 2'd2) acc_q <= '0;
			end
			S_SQ_A, S_DOT_A: acc_q <= acc_q + mp_q;
			S_SQRT_W: begin
				if (sqrt_rsp.done) begin
					norm_q <= sqrt_rsp.root;
					if (sqrt_rsp.root == '0) degen_q <= 1'b1;
				end
			end
			S_UN_W: begin
				if (div_rsp.done) begin
					case (pass_q)
						PASS_AXIS: ax_q[idx_q] <= uval;
						PASS_N1:   n1_q[idx_q] <= uval;
						default:   n2_q[idx_q] <= uval;
					endcase
					acc_q <= '0;
				end
			end
			S_DOT_R: begin
				case (dot_q)
					DOT_B1:  b1s_q <= BS_W'(round_frac(acc_q));
					DOT_B2:  b2s_q <= BS_W'(round_frac(acc_q));
					default: k14_q <= K_W'(round_frac(acc_q));
				endcase
				acc_q <= '0;
			end
			S_DEN_W: begin
				den_q <= den_c;
				if (den_c == '0) degen_q <= 1'b1;
			end
			S_NUM_M2: num_q[0] <= (NUM_W'(b1s_q) <<< FRAC) - NUM_W'(mp_q);
			S_NUM_W:  num_q[1] <= NUM_W'(mp_q) - (NUM_W'(b2s_q) <<< FRAC);
			S_RAD_W:  if (div_rsp.done) rad_q[idx_q[0]] <= rad_sat;
			S_DONE: begin
				if (out_free) begin
					o_ax_q    <= ax_q[0];
					o_ay_q    <= ax_q[1];
					o_az_q    <= ax_q[2][AXZ_W-1:0];
					o_r1_q    <= held_q[0];
					o_r2_q    <= held_q[1];
					o_degen_q <= degen_q;
					o_clr_q   <= cleared_q;
					o_cnt_q   <= COUNT_OUT_W'(total_q);
				end
			end
			default: ;
		endcase
	end

	assign result.valid          = out_valid_q;
	assign result.axis_x         = o_ax_q;
	assign result.axis_y         = o_ay_q;
	assign result.axis_z         = o_az_q;
	assign result.radius_one_avg = o_r1_q;
	assign result.radius_two_avg = o_r2_q;
	assign result.degenerate     = o_degen_q;
	assign result.window_cleared = o_clr_q;
	assign result.sample_count   = o_cnt_q;

`ifndef SYNTHESIS
	a_count_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(WINDOW_SIZE))
		else $error("sample count ran past the window");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !plates.ready)
		else $error("new transaction taken while one is in work");

	a_cleared_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.window_cleared) |-> (result.sample_count == '0))
		else $error("window cleared but count not zero");
`endif

endmodule
